// ===== hdl/verlet_particle_step_unit_defines.svh =====
// assertion macros for the verlet particle step unit checker
// expects clk_i and rst_ni in the scope of each use
`ifndef VERLET_PARTICLE_STEP_UNIT_DEFINES_SVH
`define VERLET_PARTICLE_STEP_UNIT_DEFINES_SVH

// checked only while out of reset
`define VPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define VPS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/vps_pkg.sv =====
// shared types and constants for the verlet particle step unit
// no dependencies
package vps_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP       = 3'd0,
    REG_INVERSE_MASS    = 3'd1,
    REG_WINDOW_WIDTH    = 3'd2,
    REG_WINDOW_HEIGHT   = 3'd3,
    REG_PARTICLE_RADIUS = 3'd4,
    REG_RESTITUTION     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WALL_NONE = 2'd0,
    WALL_X    = 2'd1,
    WALL_Y    = 2'd2
  } wall_sel_e;

  localparam logic [15:0] TIME_STEP_RST       = 16'd1092;
  localparam logic [15:0] INVERSE_MASS_RST    = 16'd256;
  localparam logic [14:0] WINDOW_WIDTH_RST    = 15'd800;
  localparam logic [14:0] WINDOW_HEIGHT_RST   = 15'd600;
  localparam logic [15:0] PARTICLE_RADIUS_RST = 16'd1280;
  localparam logic [16:0] RESTITUTION_RST     = 17'd52429;

  localparam int          DT2_ROUND = 32768;
  localparam logic [15:0] DT2_RST   = 16'((1092 * 1092 + DT2_ROUND) >> 16);

  // 25.5^2 * 4, green scale for the squared step length
  localparam int          GREEN_SCALE = 2601;
  localparam int          SPEED_LIMIT = 10;
  localparam int          LEVEL_W     = 8;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

endpackage

// ===== hdl/vps_accel.sv =====
// two-stage force to position delta: force * inverse mass, then * dt^2 with rounding
// depends on vps_pkg
module vps_accel #(
  parameter int PW    = 24,
  parameter int PAY_W = 97
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [PW-1:0] force_x_i,
  input  logic signed [PW-1:0] force_y_i,
  input  logic [15:0]          inv_mass_i,
  input  logic [15:0]          dt2_i,
  input  logic [PAY_W-1:0]     pay_i,
  output logic                 valid_o,
  output logic signed [PW+9:0] delta_x_o,
  output logic signed [PW+9:0] delta_y_o,
  output logic [PAY_W-1:0]     pay_o
);
  import vps_pkg::*;

  localparam int AW  = PW + 17;
  localparam int PRW = AW + 17;
  localparam int DW  = PRW - 24;
  localparam logic signed [PRW-1:0] RND_HALF = PRW'(1) << 23;

  logic                 v1_q;
  logic signed [AW-1:0] ax_q, ay_q, ax_d, ay_d;
  logic [PAY_W-1:0]     pay1_q;
  logic signed [PRW-1:0] prod_x, prod_y, rnd_x, rnd_y;
  logic signed [DW-1:0]  dx_d, dy_d;

  assign ax_d = force_x_i * $signed({1'b0, inv_mass_i});
  assign ay_d = force_y_i * $signed({1'b0, inv_mass_i});

  assign prod_x = ax_q * $signed({1'b0, dt2_i});
  assign prod_y = ay_q * $signed({1'b0, dt2_i});
  assign rnd_x  = prod_x + RND_HALF;
  assign rnd_y  = prod_y + RND_HALF;
  assign dx_d   = DW'(rnd_x >>> 24);
  assign dy_d   = DW'(rnd_y >>> 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      pay1_q    <= pay_i;
      delta_x_o <= dx_d;
      delta_y_o <= dy_d;
      pay_o     <= pay1_q;
    end
  end

endmodule

// ===== hdl/vps_green.sv =====
// pipelined search for the colour step count, one bit of the count per stage
// depends on vps_pkg
module vps_green #(
  parameter int FB    = 8,
  parameter int PAY_W = 98
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2*FB+22:0]     t_i,
  input  logic [PAY_W-1:0]     pay_i,
  output logic                 valid_o,
  output logic [vps_pkg::LEVEL_W-1:0] green_o,
  output logic [PAY_W-1:0]     pay_o
);
  import vps_pkg::*;

  localparam int TW = 2 * FB + 23;
  localparam int NS = LEVEL_W;

  logic              v_q   [NS+1];
  logic [LEVEL_W-1:0] m_q  [NS+1];
  logic [TW-1:0]     t_q   [NS+1];
  logic [PAY_W-1:0]  pay_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]   <= '0;
      t_q[0]   <= t_i;
      pay_q[0] <= pay_i;
    end
  end

  // largest m with (2m)^2 * 2^(2*FB) below t, most significant bit first
  for (genvar j = 1; j <= NS; j++) begin : g_stage
    logic [LEVEL_W-1:0]   trial;
    logic [2*LEVEL_W-1:0] sqr;
    logic [TW-1:0]        f;

    assign trial = m_q[j-1] | (LEVEL_W'(1) << (NS - j));
    assign sqr   = trial * trial;
    assign f     = TW'(sqr) << (2 * FB + 2);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[j]   <= (f < t_q[j-1]) ? trial : m_q[j-1];
        t_q[j]   <= t_q[j-1];
        pay_q[j] <= pay_q[j-1];
      end
    end
  end

  // level is LEVEL_MAX - m - 1 (zero at m = LEVEL_MAX), or LEVEL_MAX for t zero
  always_comb begin
    if (t_q[NS] == '0) begin
      green_o = LEVEL_MAX;
    end else if (m_q[NS] == LEVEL_MAX) begin
      green_o = '0;
    end else begin
      green_o = LEVEL_MAX - m_q[NS] - LEVEL_W'(1);
    end
  end

  assign valid_o = v_q[NS];
  assign pay_o   = pay_q[NS];

endmodule

// ===== hdl/verlet_particle_step_unit.sv =====
// verlet particle step unit: integration, wall bounce and colour level
// depends on vps_pkg, vps_accel and vps_green
//
// Input channel in_valid_i/in_ready_o carries one particle record per
// transaction; output channel out_valid_o/out_ready_i carries one result
// per record, in order. Registers are written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must write them only while no transaction is
// in flight, as the block itself does not enforce this. A record passes
// two multiplier stages for the force term, one for the position sum, one
// for the wall test and restitution product, nine for the colour search
// (an input register, then one bit of the step count per stage) and the
// output register. Throughput is one record per cycle while the output
// is not stalled; the pipeline advances as a whole. When the receiver
// stalls with a result held, every stage holds and in_ready_o drops;
// nothing is lost or repeated. Reset clears all valid bits and restores
// the register defaults; the first record may be taken in the cycle after
// reset is released. A register write takes effect for records accepted
// from the cycle after the write.
module verlet_particle_step_unit #(
  parameter int POSITION_WIDTH = 24,
  parameter int FRACTION_BITS  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [POSITION_WIDTH-1:0]  pos_x_i,
  input  logic signed [POSITION_WIDTH-1:0]  pos_y_i,
  input  logic signed [POSITION_WIDTH-1:0]  prev_x_i,
  input  logic signed [POSITION_WIDTH-1:0]  prev_y_i,
  input  logic signed [POSITION_WIDTH-1:0]  force_x_i,
  input  logic signed [POSITION_WIDTH-1:0]  force_y_i,
  input  logic                              pinned_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [POSITION_WIDTH-1:0]  new_pos_x_o,
  output logic signed [POSITION_WIDTH-1:0]  new_pos_y_o,
  output logic signed [POSITION_WIDTH-1:0]  new_prev_x_o,
  output logic signed [POSITION_WIDTH-1:0]  new_prev_y_o,
  output logic [vps_pkg::LEVEL_W-1:0]       green_level_o,
  output logic                              color_changed_o
);
  import vps_pkg::*;

  localparam int PW     = POSITION_WIDTH;
  localparam int FB     = FRACTION_BITS;
  localparam int DW     = PW + 10;
  localparam int CW     = PW + FB + 20;
  localparam int EW     = PW + 19;
  localparam int VW     = FB + 5;
  localparam int SQW    = 2 * VW + 1;
  localparam int TW     = 2 * FB + 23;
  localparam int RSH_L  = (FB >= 8) ? FB - 8 : 0;
  localparam int RSH_R  = (FB >= 8) ? 0 : 8 - FB;
  localparam int APAY_W = 4 * PW + 1;
  localparam int GPAY_W = 4 * PW + 2;
  localparam logic signed [CW-1:0] SAT_HI = CW'((64'sd1 <<< (PW - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);
  localparam logic signed [CW-1:0] E_HALF = CW'(1) << 15;

  function automatic logic signed [PW-1:0] sat_f(input logic signed [CW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[PW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[PW-1:0];
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [15:0] time_step_q, inv_mass_q, radius_q, dt2_q;
  logic [14:0] width_q, height_q;
  logic [16:0] restit_q;
  logic [31:0] ts_sq;
  logic [31:0] dt2_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
      inv_mass_q  <= INVERSE_MASS_RST;
      width_q     <= WINDOW_WIDTH_RST;
      height_q    <= WINDOW_HEIGHT_RST;
      radius_q    <= PARTICLE_RADIUS_RST;
      restit_q    <= RESTITUTION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TIME_STEP:       time_step_q <= cfg_data_i[15:0];
        REG_INVERSE_MASS:    inv_mass_q  <= cfg_data_i[15:0];
        REG_WINDOW_WIDTH:    width_q     <= cfg_data_i[14:0];
        REG_WINDOW_HEIGHT:   height_q    <= cfg_data_i[14:0];
        REG_PARTICLE_RADIUS: radius_q    <= cfg_data_i[15:0];
        REG_RESTITUTION:     restit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dt^2 kept registered, rounded to Q0.16; the rounded sum stays below 2^32
  assign ts_sq    = time_step_q * time_step_q;
  assign dt2_full = ts_sq + 32'(DT2_ROUND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt2_q <= DT2_RST;
    end else begin
      dt2_q <= dt2_full[31:16];
    end
  end

  // pipeline advance
  logic en;
  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  // stages A and B: force term
  logic                 a_valid;
  logic signed [DW-1:0] a_dx, a_dy;
  logic [APAY_W-1:0]    a_pay;
  logic                 a_pin;
  logic signed [PW-1:0] a_px, a_py, a_qx, a_qy;

  vps_accel #(
    .PW    (PW),
    .PAY_W (APAY_W)
  ) u_accel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .force_x_i  (force_x_i),
    .force_y_i  (force_y_i),
    .inv_mass_i (inv_mass_q),
    .dt2_i      (dt2_q),
    .pay_i      ({pinned_i, pos_x_i, pos_y_i, prev_x_i, prev_y_i}),
    .valid_o    (a_valid),
    .delta_x_o  (a_dx),
    .delta_y_o  (a_dy),
    .pay_o      (a_pay)
  );

  assign {a_pin, a_px, a_py, a_qx, a_qy} = a_pay;

  // stage C: verlet sum
  logic                 c_valid_q, c_pin_q;
  logic signed [PW-1:0] c_nx_q, c_ny_q, c_ox_q, c_oy_q;
  logic signed [PW-1:0] c_nx_d, c_ny_d, c_ox_d, c_oy_d;
  logic signed [CW-1:0] sum_x, sum_y;

  assign sum_x = CW'(a_px) + CW'(a_px) - CW'(a_qx) + CW'(a_dx);
  assign sum_y = CW'(a_py) + CW'(a_py) - CW'(a_qy) + CW'(a_dy);

  always_comb begin
    if (a_pin) begin
      c_nx_d = a_px;
      c_ny_d = a_py;
      c_ox_d = a_qx;
      c_oy_d = a_qy;
    end else begin
      c_nx_d = sat_f(sum_x);
      c_ny_d = sat_f(sum_y);
      c_ox_d = a_px;
      c_oy_d = a_py;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= a_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_pin_q <= a_pin;
      c_nx_q  <= c_nx_d;
      c_ny_q  <= c_ny_d;
      c_ox_q  <= c_ox_d;
      c_oy_q  <= c_oy_d;
    end
  end

  // stage D: wall test, restitution product, squared step
  logic signed [CW-1:0] vx, vy, rad, wall_w, wall_h, lim, px_w, py_w, vsel;
  logic signed [VW-1:0] vxs, vys;
  logic signed [2*VW-1:0] sqx, sqy;
  logic                 fast_d;
  wall_sel_e            sel_d;
  logic signed [PW-1:0] clamp_d;

  logic                 d_valid_q, d_pin_q, d_fast_q;
  wall_sel_e            d_sel_q;
  logic signed [PW-1:0] d_nx_q, d_ny_q, d_ox_q, d_oy_q, d_clamp_q;
  logic signed [EW-1:0] d_prod_q;
  logic [SQW-1:0]       d_sq_q;

  assign px_w   = CW'(c_nx_q);
  assign py_w   = CW'(c_ny_q);
  assign vx     = px_w - CW'(c_ox_q);
  assign vy     = py_w - CW'(c_oy_q);
  assign rad    = (CW'(radius_q) << RSH_L) >> RSH_R;
  assign wall_w = CW'(width_q) << FB;
  assign wall_h = CW'(height_q) << FB;
  assign lim    = CW'(SPEED_LIMIT) << FB;

  assign fast_d = (vx >= lim) || (vx <= -lim) || (vy >= lim) || (vy <= -lim);
  assign vxs    = vx[VW-1:0];
  assign vys    = vy[VW-1:0];
  assign sqx    = vxs * vxs;
  assign sqy    = vys * vys;

  // first violated wall wins: left, right, top, bottom
  always_comb begin
    sel_d   = WALL_NONE;
    clamp_d = c_nx_q;
    vsel    = vx;
    if (px_w < rad) begin
      sel_d   = WALL_X;
      clamp_d = sat_f(rad);
    end else if (px_w + rad > wall_w) begin
      sel_d   = WALL_X;
      clamp_d = sat_f(wall_w - rad);
    end else if (py_w < rad) begin
      sel_d   = WALL_Y;
      clamp_d = sat_f(rad);
      vsel    = vy;
    end else if (py_w + rad > wall_h) begin
      sel_d   = WALL_Y;
      clamp_d = sat_f(wall_h - rad);
      vsel    = vy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_pin_q   <= c_pin_q;
      d_fast_q  <= fast_d;
      d_sel_q   <= sel_d;
      d_nx_q    <= c_nx_q;
      d_ny_q    <= c_ny_q;
      d_ox_q    <= c_ox_q;
      d_oy_q    <= c_oy_q;
      d_clamp_q <= clamp_d;
      d_prod_q  <= $signed(vsel[PW:0]) * $signed({1'b0, restit_q});
      d_sq_q    <= SQW'(unsigned'(sqx)) + SQW'(unsigned'(sqy));
    end
  end

  // stage E (first register of the colour search): reflected previous position
  logic signed [CW-1:0] refl;
  logic signed [PW-1:0] q_new, e_px, e_py, e_qx, e_qy;
  logic [TW-1:0]        e_t;

  assign refl  = (CW'(d_prod_q) + E_HALF) >>> 16;
  assign q_new = sat_f(CW'(d_clamp_q) + refl);
  assign e_t   = TW'(d_sq_q) * TW'(GREEN_SCALE);

  always_comb begin
    e_px = d_nx_q;
    e_py = d_ny_q;
    e_qx = d_ox_q;
    e_qy = d_oy_q;
    unique case (d_sel_q)
      WALL_X: begin
        e_px = d_clamp_q;
        e_qx = q_new;
      end
      WALL_Y: begin
        e_py = d_clamp_q;
        e_qy = q_new;
      end
      default: ;
    endcase
  end

  logic                 g_valid, g_pin, g_fast;
  logic [LEVEL_W-1:0]   g_green;
  logic [GPAY_W-1:0]    g_pay;
  logic signed [PW-1:0] g_px, g_py, g_qx, g_qy;

  vps_green #(
    .FB    (FB),
    .PAY_W (GPAY_W)
  ) u_green (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid_q),
    .t_i     (e_t),
    .pay_i   ({d_pin_q, d_fast_q, e_px, e_py, e_qx, e_qy}),
    .valid_o (g_valid),
    .green_o (g_green),
    .pay_o   (g_pay)
  );

  assign {g_pin, g_fast, g_px, g_py, g_qx, g_qy} = g_pay;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= g_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_pos_x_o     <= g_px;
      new_pos_y_o     <= g_py;
      new_prev_x_o    <= g_qx;
      new_prev_y_o    <= g_qy;
      green_level_o   <= (g_pin || g_fast) ? '0 : g_green;
      color_changed_o <= ~g_pin;
    end
  end

endmodule

// ===== hdl/vps_checker.sv =====
// port-level checker for the verlet particle step unit, bound to the top level
// depends on vps_pkg and verlet_particle_step_unit_defines.svh
`include "verlet_particle_step_unit_defines.svh"

module vps_checker #(
  parameter int POSITION_WIDTH = 24
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [vps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input logic [vps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic signed [POSITION_WIDTH-1:0]  pos_x_i,
  input logic signed [POSITION_WIDTH-1:0]  pos_y_i,
  input logic signed [POSITION_WIDTH-1:0]  prev_x_i,
  input logic signed [POSITION_WIDTH-1:0]  prev_y_i,
  input logic signed [POSITION_WIDTH-1:0]  force_x_i,
  input logic signed [POSITION_WIDTH-1:0]  force_y_i,
  input logic                              pinned_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [POSITION_WIDTH-1:0]  new_pos_x_o,
  input logic signed [POSITION_WIDTH-1:0]  new_pos_y_o,
  input logic signed [POSITION_WIDTH-1:0]  new_prev_x_o,
  input logic signed [POSITION_WIDTH-1:0]  new_prev_y_o,
  input logic [vps_pkg::LEVEL_W-1:0]       green_level_o,
  input logic                              color_changed_o
);
  import vps_pkg::*;

  // a held result keeps its payload
  `VPS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_pos_x_o) && $stable(new_prev_y_o) && $stable(green_level_o), "result changed while stalled")

  // a pinned particle carries no colour level
  `VPS_ASSERT(a_pinned_green, out_valid_o && !color_changed_o |-> green_level_o == '0, "green level set for a pinned particle")

  // a stalled result stops the input side
  `VPS_ASSERT(a_stall_ready, out_valid_o && !out_ready_i |-> !in_ready_o, "input taken while output stalled")

  // nothing is offered while reset is held
  `VPS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind verlet_particle_step_unit vps_checker #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_vps_checker (.*);
